/* src/assert_macros.svh */
// Assertion macros for the RTL files.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

/* src/kflerp_pkg.sv */
// Package for the keyframe lerp sampler: sizes, codes and the state type.
// Depends on nothing.
`default_nettype none
package kflerp_pkg;
	localparam int KeyDepth = 256;
	localparam int IdxW = $clog2(KeyDepth);
	localparam int CntW = IdxW + 1;
	localparam int CurW = 9;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_DEL = 2'd1;
	localparam logic [1:0] CMD_RD = 2'd2;
	localparam logic [1:0] CMD_SMP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [0:0] REG_EMPTY_DEFAULT = 1'b0;

	typedef struct packed {
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} key_t;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_SCAN = 11'b00000000010,
		S_SCANW = 11'b00000000100,
		S_SHIFT = 11'b00000001000,
		S_SHIFTW = 11'b00000010000,
		S_RDA = 11'b00000100000,
		S_RDB = 11'b00001000000,
		S_DIV = 11'b00010000000,
		S_MUL = 11'b00100000000,
		S_SUM = 11'b01000000000,
		S_OUT = 11'b10000000000
	} state_t;
endpackage
`default_nettype wire

/* src/keyframe_vec3_lerp_sampler_core.sv */
// Keyframe lerp sampler top level: key memory, search, shift and blend engine.
// Depends on kflerp_pkg and assert_macros.svh.
//
// Keys live in one synchronous memory (time, x, y, z per entry) with a write
// port and a read port that work in the same cycle; read data is registered.
// Every item is handled alone. Add scans from index 0 and then moves later
// keys up one slot, writing the new key into the freed slot; delete moves
// later keys down the same way. A sample walks or searches the memory, reads
// the two neighbors, runs a 16-step restoring divider for the fraction, then
// multiplies the three components. The result sits in an output register;
// the next item is taken while it waits, and a finished item holds in the
// last state until that register is free.
`default_nettype none
`include "assert_macros.svh"
module keyframe_vec3_lerp_sampler_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] cmd,
	input wire logic [31:0] key_time,
	input wire logic signed [31:0] in_x,
	input wire logic signed [31:0] in_y,
	input wire logic signed [31:0] in_z,
	input wire logic [8:0] cursor,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] status,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [31:0] out_time,
	output logic [8:0] cursor_out
);
	localparam int IW = kflerp_pkg::IdxW;
	localparam int CW = kflerp_pkg::CntW;

	// configuration register
	logic [31:0] empty_default_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == kflerp_pkg::REG_EMPTY_DEFAULT) ? empty_default_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_default_q <= 32'd0;
		end else if (psel && penable && pwrite && paddr[2] == kflerp_pkg::REG_EMPTY_DEFAULT) begin
			empty_default_q <= pwdata;
		end
	end

	// key memory
	kflerp_pkg::key_t mem [kflerp_pkg::KeyDepth];
	logic mem_we;
	logic [IW-1:0] mem_wa, mem_ra;
	kflerp_pkg::key_t mem_wd, mem_rd_q;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	kflerp_pkg::state_t state_q;
	logic [CW-1:0] count_q;
	logic [1:0] cmd_q;
	logic [31:0] t_q;
	kflerp_pkg::key_t new_q;
	logic [8:0] cur_q;
	logic [CW-1:0] idx_q;
	logic full_search_q;
	kflerp_pkg::key_t ka_q, kb_q;
	logic [47:0] rem_q;
	logic [31:0] div_q;
	logic [15:0] frac_q;
	logic [4:0] step_q;
	logic signed [49:0] px_q, py_q, pz_q;
	logic [1:0] st_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic [31:0] ot_q;
	logic [8:0] co_q;
	logic out_v_q;
	logic [1:0] res_st_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q;
	logic [31:0] res_t_q;
	logic [8:0] res_cur_q;
	logic out_load;

	assign in_ready = (state_q == kflerp_pkg::S_IDLE);
	assign out_valid = out_v_q;
	assign status = res_st_q;
	assign out_x = res_x_q;
	assign out_y = res_y_q;
	assign out_z = res_z_q;
	assign out_time = res_t_q;
	assign cursor_out = res_cur_q;

	// output register, loaded from the finished item once it is free
	assign out_load = (state_q == kflerp_pkg::S_OUT) && (!out_v_q || out_ready);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			res_st_q <= '0;
			res_x_q <= '0;
			res_y_q <= '0;
			res_z_q <= '0;
			res_t_q <= '0;
			res_cur_q <= '0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
			res_st_q <= st_q;
			res_x_q <= ox_q;
			res_y_q <= oy_q;
			res_z_q <= oz_q;
			res_t_q <= ot_q;
			res_cur_q <= co_q;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// scan test on the key just read
	logic scan_stop;
	always_comb begin
		if (cmd_q == kflerp_pkg::CMD_ADD) scan_stop = !(mem_rd_q.t < t_q);
		else if (full_search_q) scan_stop = mem_rd_q.t > t_q;
		else scan_stop = !(mem_rd_q.t < t_q);
	end

	// trial subtract for the fraction divider
	logic [48:0] trial;
	assign trial = {rem_q, 1'b0} - {17'd0, div_q};

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q[IW-1:0];
		mem_wd = new_q;
		mem_ra = idx_q[IW-1:0];
		case (state_q)
			kflerp_pkg::S_SHIFTW: begin
				mem_we = 1'b1;
				if (cmd_q == kflerp_pkg::CMD_ADD) begin
					mem_wa = idx_q[IW-1:0];
					// the insert slot takes the new key, the others the moved one
					mem_wd = (idx_q == CW'(cur_q)) ? new_q : mem_rd_q;
				end else begin
					mem_wa = IW'(idx_q - CW'(1));
					mem_wd = mem_rd_q;
				end
			end
			kflerp_pkg::S_SHIFT: begin
				if (cmd_q == kflerp_pkg::CMD_ADD) begin
					mem_ra = IW'(idx_q - CW'(1));
				end
			end
			kflerp_pkg::S_RDA: begin
				if (idx_q == '0) mem_ra = '0;
				else mem_ra = IW'(idx_q - CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kflerp_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				kflerp_pkg::S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= cmd;
						t_q <= key_time;
						new_q <= '{key_time, in_x, in_y, in_z};
						cur_q <= cursor;
						st_q <= kflerp_pkg::ST_OK;
						ox_q <= '0;
						oy_q <= '0;
						oz_q <= '0;
						ot_q <= '0;
						co_q <= '0;
						full_search_q <= 1'b0;
						case (cmd)
							kflerp_pkg::CMD_ADD: begin
								idx_q <= '0;
								state_q <= kflerp_pkg::S_SCAN;
							end
							kflerp_pkg::CMD_DEL, kflerp_pkg::CMD_RD: begin
								if ({1'b0, cursor} >= 10'(count_q)) begin
									st_q <= kflerp_pkg::ST_RANGE;
									state_q <= kflerp_pkg::S_OUT;
								end else if (cmd == kflerp_pkg::CMD_RD) begin
									// the left-neighbor read fetches the key at cursor
									idx_q <= CW'(cursor) + CW'(1);
									state_q <= kflerp_pkg::S_RDA;
								end else begin
									idx_q <= CW'(cursor) + CW'(1);
									state_q <= kflerp_pkg::S_SHIFT;
								end
							end
							default: begin
								co_q <= cursor;
								if (count_q == '0) begin
									ox_q <= empty_default_q;
									oy_q <= empty_default_q;
									oz_q <= empty_default_q;
									state_q <= kflerp_pkg::S_OUT;
								end else if ({1'b0, cursor} > 10'(count_q)) begin
									full_search_q <= 1'b1;
									idx_q <= '0;
									state_q <= kflerp_pkg::S_SCAN;
								end else begin
									idx_q <= CW'(cursor);
									state_q <= kflerp_pkg::S_SCAN;
								end
							end
						endcase
					end
				end
				// issue a read at idx unless the scan is at the end
				kflerp_pkg::S_SCAN: begin
					if (idx_q >= count_q) begin
						if (cmd_q == kflerp_pkg::CMD_ADD) begin
							if (count_q == CW'(kflerp_pkg::KeyDepth)) begin
								st_q <= kflerp_pkg::ST_FULL;
								state_q <= kflerp_pkg::S_OUT;
							end else begin
								co_q <= 9'(idx_q);
								cur_q <= 9'(idx_q);
								idx_q <= count_q;
								state_q <= kflerp_pkg::S_SHIFT;
							end
						end else begin
							co_q <= 9'(idx_q);
							state_q <= kflerp_pkg::S_RDA;
						end
					end else begin
						state_q <= kflerp_pkg::S_SCANW;
					end
				end
				kflerp_pkg::S_SCANW: begin
					if (!scan_stop) begin
						idx_q <= idx_q + CW'(1);
						state_q <= kflerp_pkg::S_SCAN;
					end else if (cmd_q == kflerp_pkg::CMD_ADD) begin
						if (mem_rd_q.t == t_q) begin
							st_q <= kflerp_pkg::ST_DUP;
							state_q <= kflerp_pkg::S_OUT;
						end else if (count_q == CW'(kflerp_pkg::KeyDepth)) begin
							st_q <= kflerp_pkg::ST_FULL;
							state_q <= kflerp_pkg::S_OUT;
						end else begin
							co_q <= 9'(idx_q);
							cur_q <= 9'(idx_q);
							idx_q <= count_q;
							state_q <= kflerp_pkg::S_SHIFT;
						end
					end else begin
						co_q <= 9'(idx_q);
						state_q <= kflerp_pkg::S_RDA;
					end
				end
				// move keys: add goes downward from count, delete upward
				kflerp_pkg::S_SHIFT: begin
					if (cmd_q == kflerp_pkg::CMD_ADD) begin
						state_q <= kflerp_pkg::S_SHIFTW;
					end else if (idx_q >= count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= kflerp_pkg::S_OUT;
					end else begin
						state_q <= kflerp_pkg::S_SHIFTW;
					end
				end
				kflerp_pkg::S_SHIFTW: begin
					if (cmd_q == kflerp_pkg::CMD_ADD) begin
						if (idx_q == CW'(cur_q)) begin
							count_q <= count_q + CW'(1);
							state_q <= kflerp_pkg::S_OUT;
						end else begin
							idx_q <= idx_q - CW'(1);
							state_q <= kflerp_pkg::S_SHIFT;
						end
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= kflerp_pkg::S_SHIFT;
					end
				end
				// read left neighbor (or clamp), then the right
				kflerp_pkg::S_RDA: begin
					if (idx_q == '0) begin
						state_q <= kflerp_pkg::S_RDB;
					end else begin
						if (idx_q >= count_q) idx_q <= count_q - CW'(1);
						state_q <= kflerp_pkg::S_RDB;
					end
				end
				kflerp_pkg::S_RDB: begin
					ka_q <= mem_rd_q;
					if (cmd_q == kflerp_pkg::CMD_RD) begin
						state_q <= kflerp_pkg::S_SUM;
						step_q <= '1;
					end else if (idx_q == '0 || CW'(co_q) >= count_q) begin
						state_q <= kflerp_pkg::S_SUM;
						step_q <= '1;
					end else begin
						state_q <= kflerp_pkg::S_DIV;
						step_q <= '0;
					end
				end
				kflerp_pkg::S_DIV: begin
					if (step_q == '0) begin
						kb_q <= mem_rd_q;
						step_q <= 5'd1;
						if (t_q <= ka_q.t || mem_rd_q.t <= ka_q.t) begin
							step_q <= '1;
							state_q <= kflerp_pkg::S_SUM;
						end else if (t_q >= mem_rd_q.t) begin
							ka_q <= mem_rd_q;
							step_q <= '1;
							state_q <= kflerp_pkg::S_SUM;
						end else begin
							div_q <= mem_rd_q.t - ka_q.t;
							rem_q <= {16'd0, t_q - ka_q.t};
							frac_q <= '0;
						end
					end else begin
						if (!trial[48]) begin
							rem_q <= trial[47:0];
							frac_q <= {frac_q[14:0], 1'b1};
						end else begin
							rem_q <= {rem_q[46:0], 1'b0};
							frac_q <= {frac_q[14:0], 1'b0};
						end
						if (step_q == 5'd16) state_q <= kflerp_pkg::S_MUL;
						step_q <= step_q + 5'd1;
					end
				end
				kflerp_pkg::S_MUL: begin
					px_q <= (50'(signed'(kb_q.x)) - 50'(signed'(ka_q.x))) *
						signed'({34'd0, frac_q});
					py_q <= (50'(signed'(kb_q.y)) - 50'(signed'(ka_q.y))) *
						signed'({34'd0, frac_q});
					pz_q <= (50'(signed'(kb_q.z)) - 50'(signed'(ka_q.z))) *
						signed'({34'd0, frac_q});
					step_q <= '0;
					state_q <= kflerp_pkg::S_SUM;
				end
				kflerp_pkg::S_SUM: begin
					if (step_q == '1) begin
						ox_q <= ka_q.x;
						oy_q <= ka_q.y;
						oz_q <= ka_q.z;
						if (cmd_q == kflerp_pkg::CMD_RD) begin
							ot_q <= ka_q.t;
							co_q <= cur_q;
						end
					end else begin
						ox_q <= ka_q.x + 32'(px_q >>> 16);
						oy_q <= ka_q.y + 32'(py_q >>> 16);
						oz_q <= ka_q.z + 32'(pz_q >>> 16);
					end
					state_q <= kflerp_pkg::S_OUT;
				end
				// hand the item to the output register when it is free
				kflerp_pkg::S_OUT: begin
					if (out_load) state_q <= kflerp_pkg::S_IDLE;
				end
				default: state_q <= kflerp_pkg::S_IDLE;
			endcase
		end
	end

	`CHK_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(kflerp_pkg::KeyDepth))
	`CHK_IMPL(a_no_accept_busy, clk, arst_n, in_valid && in_ready,
		state_q == kflerp_pkg::S_IDLE)
	`CHK_NEXT(a_out_hold, clk, arst_n, out_v_q && !out_ready,
		out_v_q && $stable(res_cur_q) && $stable(res_x_q))
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for keyframe_vec3_lerp_sampler_core: drives commands, checks results.
// Depends on kflerp_pkg and on the core; the key table is mirrored here to predict results.
`default_nettype none
module tb_top;
	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [8:0] cur;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] st;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] t;
		logic [8:0] cur;
	} key_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic [1:0] cmd = '0;
	logic [31:0] key_time = '0;
	logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
	logic [8:0] cursor = '0;
	logic out_valid, out_ready = 1'b0;
	logic [1:0] status;
	logic signed [31:0] out_x, out_y, out_z;
	logic [31:0] out_time;
	logic [8:0] cursor_out;

	keyframe_vec3_lerp_sampler_core DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mirrored key table and register
	logic [31:0] mt_time [kflerp_pkg::KeyDepth];
	logic [31:0] mt_x [kflerp_pkg::KeyDepth];
	logic [31:0] mt_y [kflerp_pkg::KeyDepth];
	logic [31:0] mt_z [kflerp_pkg::KeyDepth];
	int key_cnt = 0;
	logic [31:0] dflt_val = '0;

	cmd_item_t pending_q[$];
	key_result_t want_q[$];
	int idle_mode = 2;
	bit hold_rx = 1'b0;
	int n_errors = 0, n_taken = 0, n_checked = 0;
	int n_hits [4];

	function automatic logic [31:0] lerp32(logic signed [31:0] v0, logic signed [31:0] v1,
			longint frac);
		longint p;
		p = (longint'(v1) - longint'(v0)) * frac;
		return 32'(longint'(v0) + (p >>> 16));
	endfunction

	// predict one result and update the mirrored table
	function automatic key_result_t keytrack_step(cmd_item_t it);
		key_result_t r;
		int pos, i, a;
		logic [63:0] num;
		longint frac;
		r = '0;
		if (it.cmd == kflerp_pkg::CMD_ADD) begin
			pos = 0;
			while (pos < key_cnt && mt_time[pos] < it.t) pos++;
			if (pos < key_cnt && mt_time[pos] == it.t) r.st = kflerp_pkg::ST_DUP;
			else if (key_cnt >= kflerp_pkg::KeyDepth) r.st = kflerp_pkg::ST_FULL;
			else begin
				for (i = key_cnt; i > pos; i--) begin
					mt_time[i] = mt_time[i-1];
					mt_x[i] = mt_x[i-1];
					mt_y[i] = mt_y[i-1];
					mt_z[i] = mt_z[i-1];
				end
				mt_time[pos] = it.t;
				mt_x[pos] = it.x;
				mt_y[pos] = it.y;
				mt_z[pos] = it.z;
				key_cnt++;
				r.st = kflerp_pkg::ST_OK;
				r.cur = 9'(pos);
			end
		end else if (it.cmd == kflerp_pkg::CMD_DEL || it.cmd == kflerp_pkg::CMD_RD) begin
			if (int'(it.cur) >= key_cnt) r.st = kflerp_pkg::ST_RANGE;
			else if (it.cmd == kflerp_pkg::CMD_RD) begin
				r.st = kflerp_pkg::ST_OK;
				r.x = mt_x[it.cur];
				r.y = mt_y[it.cur];
				r.z = mt_z[it.cur];
				r.t = mt_time[it.cur];
				r.cur = it.cur;
			end else begin
				for (i = it.cur; i + 1 < key_cnt; i++) begin
					mt_time[i] = mt_time[i+1];
					mt_x[i] = mt_x[i+1];
					mt_y[i] = mt_y[i+1];
					mt_z[i] = mt_z[i+1];
				end
				key_cnt--;
				r.st = kflerp_pkg::ST_OK;
			end
		end else if (key_cnt == 0) begin
			// empty table answers with the register value
			r.st = kflerp_pkg::ST_OK;
			r.x = dflt_val;
			r.y = dflt_val;
			r.z = dflt_val;
			r.cur = it.cur;
		end else begin
			if (int'(it.cur) > key_cnt) begin
				i = 0;
				while (i < key_cnt && mt_time[i] <= it.t) i++;
			end else begin
				i = it.cur;
				while (i < key_cnt && mt_time[i] < it.t) i++;
			end
			r.st = kflerp_pkg::ST_OK;
			r.cur = 9'(i);
			if (i == 0) begin
				r.x = mt_x[0]; r.y = mt_y[0]; r.z = mt_z[0];
			end else if (i >= key_cnt) begin
				r.x = mt_x[key_cnt-1]; r.y = mt_y[key_cnt-1]; r.z = mt_z[key_cnt-1];
			end else begin
				a = i - 1;
				if (it.t <= mt_time[a] || mt_time[i] <= mt_time[a]) begin
					r.x = mt_x[a]; r.y = mt_y[a]; r.z = mt_z[a];
				end else if (it.t >= mt_time[i]) begin
					r.x = mt_x[i]; r.y = mt_y[i]; r.z = mt_z[i];
				end else begin
					num = {32'b0, it.t - mt_time[a]} << 16;
					frac = longint'(num / {32'b0, mt_time[i] - mt_time[a]});
					r.x = lerp32(mt_x[a], mt_x[i], frac);
					r.y = lerp32(mt_y[a], mt_y[i], frac);
					r.z = lerp32(mt_z[a], mt_z[i], frac);
				end
			end
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
		n_errors++;
	endtask

	// monitor: predict on input acceptance, check on output acceptance
	bit in_taken = 1'b0;
	always @(posedge clk) begin
		key_result_t w;
		cmd_item_t it;
		in_taken <= in_valid && in_ready;
		if (out_valid && out_ready) begin
			if (want_q.size() == 0) begin
				$display("unexpected result, status %0d", status);
				n_errors++;
			end else begin
				w = want_q.pop_front();
				if (status !== w.st) report("status", 32'(status), 32'(w.st));
				if (out_x !== w.x) report("out_x", out_x, w.x);
				if (out_y !== w.y) report("out_y", out_y, w.y);
				if (out_z !== w.z) report("out_z", out_z, w.z);
				if (out_time !== w.t) report("out_time", out_time, w.t);
				if (cursor_out !== w.cur) report("cursor_out", 32'(cursor_out), 32'(w.cur));
				n_checked++;
			end
		end
		if (in_valid && in_ready) begin
			it = '{cmd, key_time, in_x, in_y, in_z, cursor};
			w = keytrack_step(it);
			want_q.push_back(w);
			n_hits[w.st]++;
			n_taken++;
		end
	end

	function automatic int tx_idle_pct();
		return idle_mode == 0 ? 30 : (idle_mode == 1 ? 88 : 0);
	endfunction

	function automatic int rx_idle_pct();
		return idle_mode == 0 ? 88 : (idle_mode == 1 ? 30 : 0);
	endfunction

	// driver: new item only once the previous one was taken
	always @(negedge clk) begin
		cmd_item_t it;
		out_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct());
		if (!in_valid || in_taken) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
				it = pending_q.pop_front();
				cmd <= it.cmd;
				key_time <= it.t;
				in_x <= it.x;
				in_y <= it.y;
				in_z <= it.z;
				cursor <= it.cur;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// poll at the rising edge, where the driven inputs are settled
	task automatic wait_idle();
		while (pending_q.size() != 0 || in_valid || want_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_default(logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {kflerp_pkg::REG_EMPTY_DEFAULT, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		dflt_val = v;
	endtask

	function automatic logic [31:0] pick_val();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(200000)) - 100000);
			2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	// coarse grid so adds collide and samples land near keys
	function automatic logic [31:0] pick_time();
		logic [31:0] g;
		g = 32'($urandom_range(63)) << 26;
		case ($urandom_range(3))
			0: return $urandom;
			1: return g;
			2: return g + 32'($urandom_range(8)) - 32'd4;
			default: return g + ($urandom & 32'h03FF_FFFF);
		endcase
	endfunction

	function automatic cmd_item_t make_item(logic [1:0] c, logic [31:0] t, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [8:0] cur);
		cmd_item_t it;
		it = '{c, t, x, y, z, cur};
		return it;
	endfunction

	function automatic logic [8:0] pick_index(int cnt);
		case ($urandom_range(5))
			0: return 9'($urandom);
			1: return 9'h1FF;
			default: return 9'($urandom_range(cnt + 1));
		endcase
	endfunction

	task automatic push_random(int n);
		int w;
		logic [1:0] c;
		for (int k = 0; k < n; k++) begin
			w = $urandom_range(99);
			if (w < (key_cnt > 40 ? 25 : 40)) c = kflerp_pkg::CMD_ADD;
			else if (w < 55) c = kflerp_pkg::CMD_DEL;
			else if (w < 70) c = kflerp_pkg::CMD_RD;
			else c = kflerp_pkg::CMD_SMP;
			pending_q.push_back(make_item(c, pick_time(), pick_val(), pick_val(), pick_val(),
				pick_index(key_cnt)));
		end
	endtask

	// long receiver stall while the sender keeps offering items
	initial begin
		wait (n_taken >= 120);
		@(negedge clk);
		hold_rx = 1'b1;
		repeat (400) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		#20000000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

	initial begin
		int n;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table with the reset default, then both extremes and a random value
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'h1234_5678, 0, 0, 0, 9'd3));
		wait_idle();
		write_default(32'h7FFF_FFFF);
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, $urandom, 0, 0, 0, 9'($urandom)));
		wait_idle();
		write_default($urandom);
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, $urandom, 0, 0, 0, 9'($urandom)));
		wait_idle();
		write_default(32'h8000_0000);

		// directed: empty table errors, extremes, duplicate, walk and search cases
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'hFFFF_FFFF, 0, 0, 0, 9'h1FF));
		pending_q.push_back(make_item(kflerp_pkg::CMD_RD, 0, 0, 0, 0, 9'd0));
		pending_q.push_back(make_item(kflerp_pkg::CMD_DEL, 0, 0, 0, 0, 9'd0));
		pending_q.push_back(make_item(kflerp_pkg::CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0, 9'h1FF));
		pending_q.push_back(make_item(kflerp_pkg::CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'h1,
			32'd12345, 9'd0));
		pending_q.push_back(make_item(kflerp_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_0000, 9'd0));
		pending_q.push_back(make_item(kflerp_pkg::CMD_ADD, 32'h8000_0000, 32'h5, 32'h5, 32'h5,
			9'd0));
		for (int k = 0; k < 4; k++)
			pending_q.push_back(make_item(kflerp_pkg::CMD_RD, 0, 0, 0, 0, 9'(k)));
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'h0, 0, 0, 0, 9'h1FF));
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'h4000_0000, 0, 0, 0, 9'd0));
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'hFFFF_FFFF, 0, 0, 0, 9'd4));
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'hC000_0000, 0, 0, 0, 9'd3));
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'hC000_0001, 0, 0, 0, 9'd2));
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'h8000_0000, 0, 0, 0, 9'd1));
		pending_q.push_back(make_item(kflerp_pkg::CMD_DEL, 0, 0, 0, 0, 9'd0));
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'h5, 0, 0, 0, 9'h1FF));
		pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, 32'h5, 0, 0, 0, 9'd0));
		pending_q.push_back(make_item(kflerp_pkg::CMD_DEL, 0, 0, 0, 0, 9'd5));
		pending_q.push_back(make_item(kflerp_pkg::CMD_DEL, 0, 0, 0, 0, 9'd1));
		wait_idle();

		// random traffic, sender mostly busy and receiver mostly stalled
		idle_mode = 0;
		for (int k = 0; k < 7; k++) begin
			push_random(20);
			wait (pending_q.size() < 4);
		end
		wait_idle();

		// other idling pattern and the positive extreme of the default
		write_default(32'h7FFF_FFFF);
		idle_mode = 1;
		for (int k = 0; k < 7; k++) begin
			push_random(20);
			wait (pending_q.size() < 4);
		end
		wait_idle();

		// fill the table to the top, then overflow it
		idle_mode = 2;
		n = kflerp_pkg::KeyDepth - key_cnt + 6;
		for (int k = 0; k < n; k++)
			pending_q.push_back(make_item(kflerp_pkg::CMD_ADD, $urandom | 32'h1, pick_val(),
				pick_val(), pick_val(), 9'd0));
		wait_idle();
		pending_q.push_back(make_item(kflerp_pkg::CMD_ADD, mt_time[7], 0, 0, 0, 9'd0));
		pending_q.push_back(make_item(kflerp_pkg::CMD_RD, 0, 0, 0, 0, 9'd255));
		pending_q.push_back(make_item(kflerp_pkg::CMD_RD, 0, 0, 0, 0, 9'd256));
		for (int k = 0; k < 8; k++)
			pending_q.push_back(make_item(kflerp_pkg::CMD_SMP, $urandom, 0, 0, 0,
				pick_index(kflerp_pkg::KeyDepth)));
		wait_idle();
		repeat (20) @(negedge clk);

		$display("%0d items taken, %0d results checked", n_taken, n_checked);
		$display("results ok %0d, duplicate %0d, full %0d, out of range %0d",
			n_hits[0], n_hits[1], n_hits[2], n_hits[3]);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
